// File: hdl/avr_subset_instruction_execute_macros.svh
// ------------------------------------------------------------------------
// Assertion macros for the AVR subset instruction executor.
// Each macro samples on the rising edge of clk and is disabled while rst
// is high, so it expects both names to be visible where it is used.
// ------------------------------------------------------------------------
`ifndef AVR_SUBSET_INSTRUCTION_EXECUTE_MACROS_SVH
`define AVR_SUBSET_INSTRUCTION_EXECUTE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASIE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/avrsie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------
// avrsie_pkg
// Shared constants, opcode codes, stage structs and an address range helper for the
// AVR subset instruction executor.
// ------------------------------------------------------------------------
package avrsie_pkg;

  // Data memory size in bytes and its address width.
  localparam int unsigned DATA_BYTES = 4096;
  localparam int unsigned ADDR_W     = $clog2(DATA_BYTES);

  // Memory map and reset values.
  localparam logic [15:0] SP_RESET      = 16'h08FF;
  localparam logic [15:0] IO_BASE       = 16'h0020;
  localparam logic [15:0] HIGH_REG_BASE = 16'h0010;

  // Status register bits.
  localparam logic [7:0] SREG_I = 8'h80;
  localparam logic [7:0] SREG_S = 8'h10;
  localparam logic [7:0] SREG_V = 8'h08;
  localparam logic [7:0] SREG_N = 8'h04;
  localparam logic [7:0] SREG_Z = 8'h02;

  // Decoded instruction codes.
  typedef enum logic [3:0] {
    OP_SBI  = 4'd0,
    OP_CBI  = 4'd1,
    OP_RJMP = 4'd2,
    OP_RETI = 4'd3,
    OP_LDI  = 4'd4,
    OP_STS  = 4'd5,
    OP_IN   = 4'd6,
    OP_SBRC = 4'd7,
    OP_ORI  = 4'd8,
    OP_SEI  = 4'd9
  } opcode_t;

  // Instruction handed from the issue stage to the execute stage.
  typedef struct packed {
    logic [3:0]  opcode;
    logic [31:0] instruction;
    logic [15:0] sp_after;
    logic [15:0] addr_a;
    logic [15:0] addr_b;
  } issue_t;

  // Pair of memory read addresses.
  typedef struct packed {
    logic [15:0] addr_a;
    logic [15:0] addr_b;
  } ram_rd_t;

  // Memory write request.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  // True when a byte address falls inside data memory.
  function automatic logic in_range(input logic [15:0] addr);
    return {1'b0, addr} < 17'(DATA_BYTES);
  endfunction

endpackage
`default_nettype wire

// File: hdl/avrsie_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------
// avrsie_if
// Valid/ready channels of the executor: the instruction channel and the
// result channel.
// ------------------------------------------------------------------------

// One decoded instruction per beat.
interface avrsie_cmd_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [31:0] instruction;

  modport source (output valid, output opcode, output instruction, input ready);
  modport sink   (input valid, input opcode, input instruction, output ready);
endinterface

// One architectural result per beat.
interface avrsie_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] pc;
  logic [15:0] sp;
  logic [7:0]  sreg;
  logic        skip_next;
  logic        write_enable;
  logic [15:0] write_address;
  logic [7:0]  write_data;

  modport source (output valid, output pc, output sp, output sreg, output skip_next,
                  output write_enable, output write_address, output write_data,
                  input ready);
  modport sink   (input valid, input pc, input sp, input sreg, input skip_next,
                  input write_enable, input write_address, input write_data,
                  output ready);
endinterface
`default_nettype wire

// File: hdl/avr_subset_instruction_execute.sv
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------
// avr_subset_instruction_execute
// Executes one decoded instruction of an 8-bit microcontroller subset per
// beat against a byte data memory holding the register file and I/O space.
//
// Usage:
//   cmd carries one decoded instruction per beat (opcode, instruction word);
//   res returns one beat per instruction with PC, SP, SREG, the skip flag
//   and the memory write the instruction made.
//   The block is a three-stage pipeline (issue, execute, result register);
//   an accepted instruction passes through the stages in that order. It
//   sustains one instruction per cycle while res is not stalled, set by the
//   single write port of the data memory, which the execute stage uses at
//   most once per instruction, with its two registered read ports feeding it.
//   A write in one cycle that the next instruction reads is forwarded.
//   After reset the data memory is cleared one byte per cycle over all
//   DATA_BYTES (4096) bytes; cmd.ready stays low until the clear is done.
//   When res is stalled the result register holds its beat, the two stages
//   behind it fill up, and cmd.ready then drops until res moves again.
// ------------------------------------------------------------------------
module avr_subset_instruction_execute (
  input  logic         clk,
  input  logic         rst,
  avrsie_cmd_if.sink   cmd,
  avrsie_res_if.source res
);
  import avrsie_pkg::*;

  logic              clr_busy;
  logic [ADDR_W-1:0] clr_idx;

  logic              s1_valid;
  issue_t            s1;
  ram_rd_t           rd;
  logic              s2_free;
  logic              s2_hold;
  ram_rd_t           hold_rd;
  ram_wr_t           wr;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr_a;
  logic [ADDR_W-1:0] ram_raddr_b;
  logic [7:0]        ram_rdata_a;
  logic [7:0]        ram_rdata_b;

  // Clearing sweep over the data memory after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      if (clr_idx == ADDR_W'(DATA_BYTES - 1)) begin
        clr_busy <= 1'b0;
      end
      clr_idx <= clr_idx + ADDR_W'(1);
    end
  end

  avrsie_issue u_issue (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .accept_en (!clr_busy),
    .s2_free   (s2_free),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .rd        (rd)
  );

  avrsie_exec u_exec (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1       (s1),
    .rdata_a  (ram_rdata_a),
    .rdata_b  (ram_rdata_b),
    .s2_free  (s2_free),
    .s2_hold  (s2_hold),
    .hold_rd  (hold_rd),
    .wr       (wr),
    .res      (res)
  );

  // Write port: the clearing sweep, then the execute stage.
  assign ram_we    = clr_busy || wr.en;
  assign ram_waddr = clr_busy ? clr_idx : wr.addr;
  assign ram_wdata = clr_busy ? 8'h00 : wr.data;

  // Read ports: a stalled execute stage keeps re-reading its own operands.
  assign ram_raddr_a = s2_hold ? hold_rd.addr_a[ADDR_W-1:0] : rd.addr_a[ADDR_W-1:0];
  assign ram_raddr_b = s2_hold ? hold_rd.addr_b[ADDR_W-1:0] : rd.addr_b[ADDR_W-1:0];

  avrsie_ram #(
    .WIDTH (8),
    .DEPTH (DATA_BYTES)
  ) u_data_mem (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

endmodule
`default_nettype wire

// File: hdl/avrsie_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------
// avrsie_ram
// Generic synchronous RAM with one write port and two read ports, each
// read registered.
// ------------------------------------------------------------------------
module avrsie_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// File: hdl/avrsie_issue.sv
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------
// avrsie_issue
// Issue stage: holds the accepted instruction, keeps the stack pointer and
// forms the data memory read addresses for the execute stage.
// ------------------------------------------------------------------------
module avrsie_issue (
  input  logic                 clk,
  input  logic                 rst,
  avrsie_cmd_if.sink           cmd,
  input  logic                 accept_en,
  input  logic                 s2_free,
  output logic                 s1_valid,
  output avrsie_pkg::issue_t   s1,
  output avrsie_pkg::ram_rd_t rd
);
  import avrsie_pkg::*;

  logic [3:0]  opcode;
  logic [31:0] instruction;
  logic [15:0] sp;
  logic [15:0] addr_a;
  logic        s1_adv;

  // The stage moves on whenever the execute stage can take it.
  assign s1_adv    = s1_valid && s2_free;
  assign cmd.ready = accept_en && (!s1_valid || s1_adv);

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      opcode      <= cmd.opcode;
      instruction <= cmd.instruction;
    end
  end

  // The stack pointer only moves on a return, so it is settled at issue.
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= SP_RESET;
    end else if (s1_adv && opcode == OP_RETI) begin
      sp <= sp + 16'd2;
    end
  end

  // Read address of the first operand byte.
  always_comb begin
    case (opcode)
      OP_SBI, OP_CBI: addr_a = IO_BASE + {11'd0, instruction[7:3]};
      OP_RETI:        addr_a = sp;
      OP_STS:         addr_a = {11'd0, instruction[24:20]};
      OP_IN:          addr_a = IO_BASE + {10'd0, instruction[10:9], instruction[3:0]};
      OP_SBRC:        addr_a = {11'd0, instruction[8:4]};
      OP_ORI:         addr_a = HIGH_REG_BASE + {12'd0, instruction[7:4]};
      default:        addr_a = 16'd0;
    endcase
  end

  // The second port only serves the low byte of a popped return address.
  assign rd.addr_a         = addr_a;
  assign rd.addr_b         = sp + 16'd1;
  assign s1.opcode         = opcode;
  assign s1.instruction    = instruction;
  assign s1.sp_after       = (opcode == OP_RETI) ? sp + 16'd2 : sp;
  assign s1.addr_a         = addr_a;
  assign s1.addr_b         = sp + 16'd1;

endmodule
`default_nettype wire

// File: hdl/avrsie_exec.sv
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------
// avrsie_exec
// Execute stage: takes the operand bytes from memory, forwards the write
// of the previous cycle, updates PC and SREG, writes memory back and loads
// the result register.
// ------------------------------------------------------------------------
module avrsie_exec (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s1_valid,
  input  avrsie_pkg::issue_t   s1,
  input  logic [7:0]           rdata_a,
  input  logic [7:0]           rdata_b,
  output logic                 s2_free,
  output logic                 s2_hold,
  output avrsie_pkg::ram_rd_t hold_rd,
  output avrsie_pkg::ram_wr_t wr,
  avrsie_res_if.source         res
);
  import avrsie_pkg::*;

  logic        s2_valid;
  issue_t      s2;
  logic        out_free;
  logic        s2_adv;

  logic        fwd_valid;
  logic [15:0] fwd_addr;
  logic [7:0]  fwd_data;

  logic [15:0] pc;
  logic [7:0]  sreg;

  logic [7:0]  byte_a;
  logic [7:0]  byte_b;
  logic [31:0] ins;
  logic [7:0]  k8;
  logic [7:0]  sel_mask;
  logic [7:0]  or_res;
  logic [15:0] pc_next;
  logic [7:0]  sreg_next;
  logic        skip;
  logic        wen_raw;
  logic        wen;
  logic [15:0] waddr;
  logic [7:0]  wdata;

  logic        out_valid;
  logic [15:0] out_pc;
  logic [15:0] out_sp;
  logic [7:0]  out_sreg;
  logic        out_skip;
  logic        out_we;
  logic [15:0] out_waddr;
  logic [7:0]  out_wdata;

  // Handshake between the stage and the result register.
  assign out_free = !out_valid || res.ready;
  assign s2_adv   = s2_valid && out_free;
  assign s2_free  = !s2_valid || s2_adv;
  assign s2_hold  = s2_valid && !out_free;
  assign hold_rd  = '{addr_a: s2.addr_a, addr_b: s2.addr_b};

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_valid && s2_free) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_free) begin
      s2 <= s1;
    end
  end

  // Operand bytes: the write of the previous cycle wins over the memory,
  // and addresses beyond memory read as zero.
  always_comb begin
    if (!in_range(s2.addr_a)) begin
      byte_a = 8'h00;
    end else if (fwd_valid && fwd_addr == s2.addr_a) begin
      byte_a = fwd_data;
    end else begin
      byte_a = rdata_a;
    end
    if (!in_range(s2.addr_b)) begin
      byte_b = 8'h00;
    end else if (fwd_valid && fwd_addr == s2.addr_b) begin
      byte_b = fwd_data;
    end else begin
      byte_b = rdata_b;
    end
  end

  assign ins      = s2.instruction;
  assign k8       = {ins[11:8], ins[3:0]};
  assign sel_mask = 8'd1 << ins[2:0];
  assign or_res   = byte_a | k8;

  // Instruction semantics.
  always_comb begin
    pc_next   = pc;
    sreg_next = sreg;
    skip      = 1'b0;
    wen_raw   = 1'b0;
    waddr     = 16'd0;
    wdata     = 8'h00;
    case (s2.opcode)
      OP_SBI: begin
        wen_raw = 1'b1;
        waddr   = s2.addr_a;
        wdata   = byte_a | sel_mask;
      end
      OP_CBI: begin
        wen_raw = 1'b1;
        waddr   = s2.addr_a;
        wdata   = byte_a & ~sel_mask;
      end
      OP_RJMP: begin
        pc_next = pc + {{3{ins[11]}}, ins[11:0], 1'b0};
      end
      OP_RETI: begin
        pc_next = {byte_a, byte_b};
      end
      OP_LDI: begin
        wen_raw = 1'b1;
        waddr   = HIGH_REG_BASE + {12'd0, ins[7:4]};
        wdata   = k8;
      end
      OP_STS: begin
        wen_raw = 1'b1;
        waddr   = ins[15:0];
        wdata   = byte_a;
      end
      OP_IN: begin
        wen_raw = 1'b1;
        waddr   = {11'd0, ins[8:4]};
        wdata   = byte_a;
      end
      OP_SBRC: begin
        skip = !byte_a[ins[2:0]];
      end
      OP_ORI: begin
        wen_raw   = 1'b1;
        waddr     = s2.addr_a;
        wdata     = or_res;
        sreg_next = (sreg & ~(SREG_S | SREG_V | SREG_N | SREG_Z))
                  | (or_res[7] ? (SREG_N | SREG_S) : 8'h00)
                  | ((or_res == 8'h00) ? SREG_Z : 8'h00);
      end
      OP_SEI: begin
        sreg_next = sreg | SREG_I;
      end
      default: begin
        pc_next = pc;
      end
    endcase
  end

  // Writes beyond memory are dropped.
  assign wen     = wen_raw && in_range(waddr);
  assign wr.en   = s2_adv && wen;
  assign wr.addr = waddr[ADDR_W-1:0];
  assign wr.data = wdata;

  // Forwarding register for a read issued in the same cycle as a write.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr.en;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= waddr;
    fwd_data <= wdata;
  end

  // Architectural PC and status byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= 16'd0;
      sreg <= 8'h00;
    end else if (s2_adv) begin
      pc   <= pc_next;
      sreg <= sreg_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_pc    <= pc_next;
      out_sp    <= s2.sp_after;
      out_sreg  <= sreg_next;
      out_skip  <= skip;
      out_we    <= wen;
      out_waddr <= wen ? waddr : 16'd0;
      out_wdata <= wen ? wdata : 8'h00;
    end
  end

  assign res.valid         = out_valid;
  assign res.pc            = out_pc;
  assign res.sp            = out_sp;
  assign res.sreg          = out_sreg;
  assign res.skip_next     = out_skip;
  assign res.write_enable  = out_we;
  assign res.write_address = out_waddr;
  assign res.write_data    = out_wdata;

endmodule
`default_nettype wire

// File: hdl/avrsie_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------
// avrsie_checker
// Port-level checks of the executor, attached to the top level by bind.
// ------------------------------------------------------------------------
`include "avr_subset_instruction_execute_macros.svh"

module avrsie_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cmd_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [15:0] res_pc,
  input wire logic        res_skip_next,
  input wire logic        res_write_enable,
  input wire logic [15:0] res_write_address,
  input wire logic [7:0]  res_write_data
);
  import avrsie_pkg::*;

  // The memory clear keeps the instruction channel closed right after reset.
  `ASIE_ASSERT_SAME(a_clear_after_reset, $past(rst), !cmd_ready, "ready high during memory clear")

  // A beat without a write reports a zero address and zero data.
  `ASIE_ASSERT_SAME(a_idle_write_zero, res_valid && !res_write_enable, (res_write_address == 16'd0) && (res_write_data == 8'h00), "write fields not zero without a write")

  // A reported write always lies inside the data memory.
  `ASIE_ASSERT_SAME(a_write_in_range, res_valid && res_write_enable, in_range(res_write_address), "write reported beyond memory")

  // A skip test never writes memory.
  `ASIE_ASSERT_SAME(a_skip_no_write, res_valid && res_skip_next, !res_write_enable, "skip beat carries a write")

  // A stalled result beat holds.
  `ASIE_ASSERT_NEXT(a_result_holds, res_valid && !res_ready, res_valid && $stable(res_pc) && $stable(res_write_data), "stalled result changed")

endmodule

bind avr_subset_instruction_execute avrsie_checker u_checker (
  .clk               (clk),
  .rst               (rst),
  .cmd_ready         (cmd.ready),
  .res_valid         (res.valid),
  .res_ready         (res.ready),
  .res_pc            (res.pc),
  .res_skip_next     (res.skip_next),
  .res_write_enable  (res.write_enable),
  .res_write_address (res.write_address),
  .res_write_data    (res.write_data)
);
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tb
// Self-checking bench for the AVR subset instruction executor. A directed
// table walks the field extremes, every opcode and the memory-range corner
// cases. A sweep of RETI beats then carries the stack pointer past the top
// of data memory, so that pops straddle the boundary and then read beyond
// it. Random instructions, biased toward register hazards and stack
// writes, fill the rest. Every result beat is compared with its hand-written
// expectation or an in-bench model of the architectural state, with bursty
// input and a stalling result side.
// ------------------------------------------------------------------------
module tb;
  import avrsie_pkg::*;

  // Opcode values with no instruction behind them.
  localparam logic [3:0] OP_UNUSED_LO = 4'd10;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  // Address window around the reset stack pointer that STS targets often.
  localparam int unsigned STACK_LO = 'h0800;
  localparam int unsigned STACK_HI = 'h0A00;

  localparam int DIRECTED_ROWS  = 26;
  localparam int RANDOM_FIRST   = 90;
  localparam int RANDOM_SECOND  = 40;
  localparam int SWEEP_RETI     = 900;
  localparam int HOLD_AFTER     = 150;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int MAX_PRINTED    = 40;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_QUARTER,
    READY_ALTERNATE
  } ready_mode_t;

  // Architectural state reported by one result beat.
  typedef struct packed {
    logic [15:0] pc;
    logic [15:0] sp;
    logic [7:0]  sreg;
    logic        skip_next;
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
  } arch_result_t;

  // One instruction beat; known marks a hand-written expected result.
  typedef struct packed {
    logic [3:0]   opcode;
    logic [31:0]  instruction;
    logic         known;
    arch_result_t result;
  } stim_t;

  logic clk;
  logic rst;

  avrsie_cmd_if cmd_ch ();
  avrsie_res_if res_ch ();

  avr_subset_instruction_execute DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  // Model of the executor state.
  logic [7:0]  data_model [DATA_BYTES];
  logic [15:0] pc_model;
  logic [15:0] sp_model;
  logic [7:0]  sreg_model;

  stim_t        instr_queue[$];
  arch_result_t pending_results[$];
  stim_t        directed_table [DIRECTED_ROWS];

  int          errors;
  int          accepted_count;
  int          results_seen;
  int          dropped_writes;
  int          far_reads;
  int          idle_cycles;
  int          hold_left;
  bit          hold_done;
  int          segment_left;
  int          phase;
  ready_mode_t stall_mode;

  // Clock and a single reset pulse.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // One line per mismatch; printing stops after MAX_PRINTED of them, counting does not.
  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("mismatch at result %0d, %s: got %h, expected %h",
               results_seen, what, got, want);
  endtask

  function automatic logic [7:0] load_byte(input logic [15:0] addr);
    if (addr < DATA_BYTES) return data_model[addr[ADDR_W-1:0]];
    far_reads++;
    return 8'h00;
  endfunction

  // A store outside memory is dropped and leaves no write in the result.
  function automatic void store_byte(input logic [15:0] addr, input logic [7:0] data,
                                     inout arch_result_t r);
    if (addr < DATA_BYTES) begin
      data_model[addr[ADDR_W-1:0]] = data;
      r.write_enable  = 1'b1;
      r.write_address = addr;
      r.write_data    = data;
    end else begin
      dropped_writes++;
    end
  endfunction

  // Executes one instruction on the model and returns the state it leaves.
  task automatic execute_model(input logic [3:0] op, input logic [31:0] ins,
                               output arch_result_t r);
    logic [7:0]  k8;
    logic [7:0]  value;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [4:0]  d5;
    logic [3:0]  d4;
    logic [2:0]  bit_sel;
    logic [4:0]  a5;
    logic [5:0]  a6;
    logic [15:0] offset;
    r       = '0;
    k8      = {ins[11:8], ins[3:0]};
    d5      = ins[8:4];
    d4      = ins[7:4];
    bit_sel = ins[2:0];
    a5      = ins[7:3];
    a6      = {ins[10:9], ins[3:0]};
    case (op)
      OP_SBI: store_byte(IO_BASE + a5, load_byte(IO_BASE + a5) | (8'h01 << bit_sel), r);
      OP_CBI: store_byte(IO_BASE + a5, load_byte(IO_BASE + a5) & ~(8'h01 << bit_sel), r);
      OP_RJMP: begin
        offset   = {{4{ins[11]}}, ins[11:0]};
        pc_model = pc_model + (offset << 1);
      end
      OP_RETI: begin
        hi       = load_byte(sp_model);
        lo       = load_byte(sp_model + 16'd1);
        pc_model = {hi, lo};
        sp_model = sp_model + 16'd2;
      end
      OP_LDI: store_byte(HIGH_REG_BASE + d4, k8, r);
      OP_STS: store_byte(ins[15:0], load_byte({11'd0, ins[24:20]}), r);
      OP_IN:  store_byte({11'd0, d5}, load_byte(IO_BASE + a6), r);
      OP_SBRC: begin
        value       = load_byte({11'd0, d5});
        r.skip_next = ~value[bit_sel];
      end
      OP_ORI: begin
        value = load_byte(HIGH_REG_BASE + d4) | k8;
        store_byte(HIGH_REG_BASE + d4, value, r);
        sreg_model = sreg_model & ~(SREG_S | SREG_V | SREG_N | SREG_Z);
        if (value[7]) sreg_model = sreg_model | SREG_N | SREG_S;
        if (value == 8'h00) sreg_model = sreg_model | SREG_Z;
      end
      OP_SEI: sreg_model = sreg_model | SREG_I;
      default: ;
    endcase
    r.pc   = pc_model;
    r.sp   = sp_model;
    r.sreg = sreg_model;
  endtask

  // Random instruction; half of them keep to r16..r19 so that results
  // feed the next few instructions, and STS often hits I/O or the stack.
  function automatic stim_t random_item();
    stim_t item;
    item             = '0;
    item.instruction = $urandom();
    if ($urandom_range(0, 15) == 0)
      item.opcode = 4'($urandom_range(int'(OP_UNUSED_LO), int'(OP_UNUSED_HI)));
    else
      item.opcode = 4'($urandom_range(int'(OP_SBI), int'(OP_SEI)));
    if ($urandom_range(0, 1) == 0) begin
      item.instruction[8:6]   = 3'b100;
      item.instruction[24:22] = 3'b100;
    end
    case (item.opcode)
      OP_STS: begin
        case ($urandom_range(0, 3))
          0: item.instruction[15:0] = 16'($urandom_range(0, 'h5F));
          1: item.instruction[15:0] = 16'($urandom_range(STACK_LO, STACK_HI));
          2: item.instruction[15:0] = 16'($urandom_range(0, DATA_BYTES - 1));
          default: ;
        endcase
      end
      OP_ORI: begin
        if ($urandom_range(0, 3) == 0) begin
          item.instruction[11:8] = 4'h0;
          item.instruction[3:0]  = 4'h0;
        end
      end
      default: ;
    endcase
    return item;
  endfunction

  // Compares one result beat with the oldest expectation.
  task automatic check_result(input arch_result_t got);
    arch_result_t want;
    if (pending_results.size() == 0) begin
      report("result with nothing pending", {16'h0000, got.pc}, 32'h0);
      return;
    end
    want = pending_results.pop_front();
    if (got.pc !== want.pc) report("pc", got.pc, want.pc);
    if (got.sp !== want.sp) report("sp", got.sp, want.sp);
    if (got.sreg !== want.sreg) report("sreg", got.sreg, want.sreg);
    if (got.skip_next !== want.skip_next) report("skip_next", got.skip_next, want.skip_next);
    if (got.write_enable !== want.write_enable)
      report("write_enable", got.write_enable, want.write_enable);
    if (got.write_address !== want.write_address)
      report("write_address", got.write_address, want.write_address);
    if (got.write_data !== want.write_data)
      report("write_data", got.write_data, want.write_data);
  endtask

  // Instruction side: builds the stimulus, then offers it in bursts.
  initial begin : instruction_side
    arch_result_t predicted;
    int           burst_left;
    int           gap_left;
    bit           accepted;

    cmd_ch.valid       <= 1'b0;
    cmd_ch.opcode      <= '0;
    cmd_ch.instruction <= '0;

    foreach (data_model[i]) data_model[i] = 8'h00;
    pc_model   = 16'h0000;
    sp_model   = SP_RESET;
    sreg_model = 8'h00;

    // Directed rows: field extremes, every opcode, memory-range corners.
    directed_table = '{
      '{OP_UNUSED_HI, 32'hFFFF_FFFF, 1'b1,
        '{16'h0000, 16'h08FF, 8'h00, 1'b0, 1'b0, 16'h0000, 8'h00}},
      '{OP_RETI, 32'h0000_0000, 1'b1,
        '{16'h0000, 16'h0901, 8'h00, 1'b0, 1'b0, 16'h0000, 8'h00}},
      '{OP_SBI, 32'h0000_00FF, 1'b1,
        '{16'h0000, 16'h0901, 8'h00, 1'b0, 1'b1, 16'h003F, 8'h80}},
      '{OP_SBI, 32'h0000_0000, 1'b1,
        '{16'h0000, 16'h0901, 8'h00, 1'b0, 1'b1, 16'h0020, 8'h01}},
      '{OP_CBI, 32'h0000_00FF, 1'b1,
        '{16'h0000, 16'h0901, 8'h00, 1'b0, 1'b1, 16'h003F, 8'h00}},
      '{OP_CBI, 32'h0000_0000, 1'b1,
        '{16'h0000, 16'h0901, 8'h00, 1'b0, 1'b1, 16'h0020, 8'h00}},
      '{OP_LDI, 32'h0000_0FFF, 1'b1,
        '{16'h0000, 16'h0901, 8'h00, 1'b0, 1'b1, 16'h001F, 8'hFF}},
      '{OP_LDI, 32'h0000_0000, 1'b1,
        '{16'h0000, 16'h0901, 8'h00, 1'b0, 1'b1, 16'h0010, 8'h00}},
      '{OP_ORI, 32'h0000_0000, 1'b1,
        '{16'h0000, 16'h0901, 8'h02, 1'b0, 1'b1, 16'h0010, 8'h00}},
      '{OP_ORI, 32'h0000_08F0, 1'b1,
        '{16'h0000, 16'h0901, 8'h14, 1'b0, 1'b1, 16'h001F, 8'hFF}},
      '{OP_SEI, 32'hFFFF_FFFF, 1'b1,
        '{16'h0000, 16'h0901, 8'h94, 1'b0, 1'b0, 16'h0000, 8'h00}},
      '{OP_SBRC, 32'h0000_01F7, 1'b1,
        '{16'h0000, 16'h0901, 8'h94, 1'b0, 1'b0, 16'h0000, 8'h00}},
      '{OP_SBRC, 32'h0000_0000, 1'b1,
        '{16'h0000, 16'h0901, 8'h94, 1'b1, 1'b0, 16'h0000, 8'h00}},
      '{OP_STS, 32'h01F0_0FFF, 1'b1,
        '{16'h0000, 16'h0901, 8'h94, 1'b0, 1'b1, 16'h0FFF, 8'hFF}},
      '{OP_STS, 32'h01F0_1000, 1'b1,
        '{16'h0000, 16'h0901, 8'h94, 1'b0, 1'b0, 16'h0000, 8'h00}},
      '{OP_STS, 32'h01F0_FFFF, 1'b1,
        '{16'h0000, 16'h0901, 8'h94, 1'b0, 1'b0, 16'h0000, 8'h00}},
      '{OP_IN, 32'h0000_07FF, 1'b1,
        '{16'h0000, 16'h0901, 8'h94, 1'b0, 1'b1, 16'h001F, 8'h00}},
      '{OP_SBI, 32'h0000_00FB, 1'b1,
        '{16'h0000, 16'h0901, 8'h94, 1'b0, 1'b1, 16'h003F, 8'h08}},
      '{OP_IN, 32'h0000_025F, 1'b1,
        '{16'h0000, 16'h0901, 8'h94, 1'b0, 1'b1, 16'h0005, 8'h08}},
      '{OP_RJMP, 32'h0000_07FF, 1'b1,
        '{16'h0FFE, 16'h0901, 8'h94, 1'b0, 1'b0, 16'h0000, 8'h00}},
      '{OP_RJMP, 32'h0000_0800, 1'b1,
        '{16'hFFFE, 16'h0901, 8'h94, 1'b0, 1'b0, 16'h0000, 8'h00}},
      '{OP_RJMP, 32'hFFFF_0001, 1'b1,
        '{16'h0000, 16'h0901, 8'h94, 1'b0, 1'b0, 16'h0000, 8'h00}},
      '{OP_LDI, 32'h0000_0122, 1'b0, '0},
      '{OP_STS, 32'h0120_0901, 1'b0, '0},
      '{OP_RETI, 32'h0000_0000, 1'b0, '0},
      '{OP_UNUSED_LO, 32'hA5A5_5A5A, 1'b0, '0}
    };

    foreach (directed_table[i]) instr_queue.push_back(directed_table[i]);
    repeat (RANDOM_FIRST) instr_queue.push_back(random_item());
    // Stack sweep: SP climbs across the end of memory and beyond it.
    repeat (SWEEP_RETI) instr_queue.push_back('{OP_RETI, $urandom(), 1'b0, '0});
    repeat (RANDOM_SECOND) instr_queue.push_back(random_item());

    @(posedge clk);
    while (rst) @(posedge clk);

    // Offer beats in bursts; the shown beat is always the queue head.
    burst_left = $urandom_range(1, 40);
    gap_left   = 0;
    while (instr_queue.size() != 0) begin
      @(posedge clk);
      accepted = cmd_ch.valid && cmd_ch.ready;
      if (accepted) begin
        execute_model(instr_queue[0].opcode, instr_queue[0].instruction, predicted);
        pending_results.push_back(instr_queue[0].known ? instr_queue[0].result : predicted);
        void'(instr_queue.pop_front());
        accepted_count++;
      end
      if (!cmd_ch.valid || accepted) begin
        if (gap_left > 0 || instr_queue.size() == 0) begin
          if (gap_left > 0) gap_left--;
          cmd_ch.valid <= 1'b0;
        end else begin
          cmd_ch.valid       <= 1'b1;
          cmd_ch.opcode      <= instr_queue[0].opcode;
          cmd_ch.instruction <= instr_queue[0].instruction;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end

    // Drain the pipeline, then give stray beats a chance to show up.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d instructions: %0d directed, %0d RETI in the stack sweep, rest random",
             accepted_count, DIRECTED_ROWS, SWEEP_RETI);
    $display("checked %0d results; %0d stores dropped and %0d reads beyond memory; %0d mismatches",
             results_seen, dropped_writes, far_reads, errors);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Result side: checks each beat and stalls on a pattern of its own,
  // with one long hold-off that backs the pipeline up into the input.
  always @(posedge clk) begin : result_side
    logic next_ready;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        check_result('{res_ch.pc, res_ch.sp, res_ch.sreg, res_ch.skip_next,
                       res_ch.write_enable, res_ch.write_address, res_ch.write_data});
        results_seen++;
      end
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else begin
        if (segment_left == 0) begin
          stall_mode   = ready_mode_t'($urandom_range(0, 3));
          segment_left = $urandom_range(10, 150);
        end
        segment_left--;
        phase++;
        case (stall_mode)
          READY_ALWAYS:  next_ready = 1'b1;
          READY_RANDOM:  next_ready = 1'($urandom_range(0, 1));
          READY_QUARTER: next_ready = (phase % 4) == 0;
          default:       next_ready = phase[0];
        endcase
      end
      res_ch.ready <= next_ready;
    end
  end

  // Watchdog: too long without a beat on either channel ends the run.
  always @(posedge clk) begin : watchdog
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
